### hdl/glmf_pkg.sv
// Package for the gyro low-pass and running median filter.
// Holds field widths, register index codes, reset values and the cell control struct.
// No dependencies.
package glmf_pkg;

	// Field widths
	localparam int SAMPLE_W   = 16;
	localparam int RATE_W     = 17;
	localparam int ALPHA_W    = 9;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;
	localparam int M_TDATA_W  = 24;

	// Default structure parameters
	localparam int WINDOW_DEF    = 10;
	localparam int FRAC_BITS_DEF = 8;

	// Unity weight in Q1.8 and the reset weight (about 0.4)
	localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 9'd256;
	localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd102;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_Q8    = 8'd1;

	// Control broadcast from the sequencer to every median cell
	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctrl_t;

endpackage

### hdl/gyro_lowpass_median_filter_unit.sv
// Gyro z-rate low-pass filter followed by a running upper median over WINDOW values.
// The input is accepted only in the idle state, so a new sample waits until the last result
// is registered at the output; the WINDOW - 1 shift passes of the cell ring dominate that wait.
// Reset (arst_n low, asynchronous) clears the filter state, history ring, write slot and
// registers to zero offset and weight 102. Depends on glmf_pkg, glmf_iir and glmf_cell.
module gyro_lowpass_median_filter_unit import glmf_pkg::*; #(
	parameter int WINDOW    = WINDOW_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [SAMPLE_W-1:0]   s_tdata,   // [15:0] gyro_sample
	// Output stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,   // [16:0] median_rate, [23:17] zero
	// Configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W = $clog2(WINDOW);
	localparam logic [IDX_W-1:0] LAST_SLOT  = IDX_W'(WINDOW - 1);
	localparam logic [IDX_W-1:0] LAST_SHIFT = IDX_W'(WINDOW - 2);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_FILT  = 3'd1;
	localparam logic [2:0] ST_LOAD  = 3'd2;
	localparam logic [2:0] ST_SHIFT = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	logic [2:0]                state_q;
	logic [IDX_W-1:0]          write_slot_q;
	logic [IDX_W-1:0]          shift_cnt_q;
	logic signed [SAMPLE_W-1:0] zero_offset_q;
	logic [ALPHA_W-1:0]        alpha_q;
	logic                      m_valid_q;
	logic signed [RATE_W-1:0]  m_data_q;

	logic                      in_xfer;
	logic                      iir_done;
	logic signed [RATE_W-1:0]  iir_whole;
	cell_ctrl_t                cell_ctrl;
	logic signed [RATE_W-1:0]  circ_val [WINDOW];
	logic [IDX_W-1:0]          circ_idx [WINDOW];
	logic signed [RATE_W-1:0]  med_val  [WINDOW];
	logic [WINDOW-1:0]         is_med;
	logic signed [RATE_W-1:0]  median;
	logic                      out_free;

	// Configuration registers; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_offset_q <= '0;
			alpha_q       <= ALPHA_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ZERO_OFFSET: zero_offset_q <= cfg_data[SAMPLE_W-1:0];
				REG_ALPHA_Q8:    alpha_q       <= cfg_data[ALPHA_W-1:0];
				default: ;
			endcase
		end
	end

	// Low-pass filter datapath.
	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;

	glmf_iir #(
		.FRAC_BITS(FRAC_BITS)
	) u_iir (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (in_xfer),
		.gyro_sample(s_tdata),
		.zero_offset(zero_offset_q),
		.alpha_q8   (alpha_q),
		.done       (iir_done),
		.whole      (iir_whole)
	);

	// Cell ring: each cell takes its neighbor's circulating value every shift cycle.
	assign cell_ctrl.load  = (state_q == ST_LOAD);
	assign cell_ctrl.shift = (state_q == ST_SHIFT);

	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		localparam int PREV = (i == 0) ? WINDOW - 1 : i - 1;
		glmf_cell #(
			.WINDOW(WINDOW),
			.SLOT  (i)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (cell_ctrl),
			.wr_en       ((state_q == ST_FILT) && iir_done && (write_slot_q == IDX_W'(i))),
			.wr_data     (iir_whole),
			.circ_val_in (circ_val[PREV]),
			.circ_idx_in (circ_idx[PREV]),
			.circ_val_out(circ_val[i]),
			.circ_idx_out(circ_idx[i]),
			.is_med      (is_med[i]),
			.med_val     (med_val[i])
		);
	end

	// Exactly one cell holds the median rank; merge the masked values.
	always_comb begin
		median = '0;
		for (int k = 0; k < WINDOW; k++) begin
			median = median | med_val[k];
		end
	end

	// Sequencer.
	assign out_free = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			write_slot_q <= '0;
			shift_cnt_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_FILT;
					end
				end
				ST_FILT: begin
					if (iir_done) begin
						write_slot_q <= (write_slot_q == LAST_SLOT) ? '0 : write_slot_q + 1'b1;
						state_q      <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					shift_cnt_q <= '0;
					state_q     <= ST_SHIFT;
				end
				ST_SHIFT: begin
					shift_cnt_q <= shift_cnt_q + 1'b1;
					if (shift_cnt_q == LAST_SHIFT) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register; a waiting result holds until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if ((state_q == ST_OUT) && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && out_free) begin
			m_data_q <= median;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(M_TDATA_W - RATE_W){1'b0}}, m_data_q};

`ifndef SYNTHESIS
	// Ranks form a permutation, so one cell alone claims the median.
	a_one_median: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> $onehot(is_med))
		else $error("median rank held by zero or several cells");

	// The filter finishes only while the sequencer waits for it.
	a_done_in_filt: assert property (@(posedge clk) disable iff (!arst_n)
		iir_done |-> (state_q == ST_FILT))
		else $error("filter result arrived outside the filter wait");

	// The write slot stays inside the ring.
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		write_slot_q <= LAST_SLOT)
		else $error("write slot beyond the ring");
`endif

endmodule

### hdl/glmf_iir.sv
// First-order low-pass stage: bias removal, weighted sum and truncation to an integer.
// Depends on glmf_pkg. Four pipeline stages from start to done.
module glmf_iir import glmf_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [SAMPLE_W-1:0] gyro_sample,
	input  logic signed [SAMPLE_W-1:0] zero_offset,
	input  logic        [ALPHA_W-1:0]  alpha_q8,
	output logic                       done,
	output logic signed [RATE_W-1:0]   whole
);

	localparam int XW      = RATE_W + FRAC_BITS;
	localparam int PREV_W  = RATE_W + FRAC_BITS + 1;
	localparam int PW      = PREV_W + ALPHA_W + 1;
	localparam int AW      = PW + 1;
	localparam int SCALE_W = 8;

	logic                      v_s1, v_s2, v_s3, v_s4;
	logic signed [RATE_W-1:0]  x_s1;
	logic        [ALPHA_W-1:0] a_s1;
	logic signed [PW-1:0]      p_new_s2, p_old_s2;
	logic signed [PREV_W-1:0]  filter_prev_q;
	logic signed [RATE_W-1:0]  whole_s4;

	logic signed [XW-1:0]      x_big;
	logic        [ALPHA_W-1:0] b_weight;
	logic signed [AW-1:0]      acc;
	logic signed [AW-1:0]      acc_adj;
	logic signed [AW-1:0]      y_full;
	logic signed [PREV_W-1:0]  prev_adj;
	logic signed [PREV_W-1:0]  whole_full;

	// Valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Stage 1: remove the bias and saturate the weight to one.
	always_ff @(posedge clk) begin
		if (start) begin
			x_s1 <= RATE_W'(gyro_sample) - RATE_W'(zero_offset);
			a_s1 <= (alpha_q8 > ALPHA_ONE) ? ALPHA_ONE : alpha_q8;
		end
	end

	// Stage 2: the two weighted products.
	assign x_big    = XW'(x_s1) <<< FRAC_BITS;
	assign b_weight = ALPHA_ONE - a_s1;

	always_ff @(posedge clk) begin
		if (v_s1) begin
			p_new_s2 <= PW'($signed({1'b0, a_s1})) * PW'(x_big);
			p_old_s2 <= PW'($signed({1'b0, b_weight})) * PW'(filter_prev_q);
		end
	end

	// Stage 3: sum and divide by the weight scale, rounding toward zero.
	assign acc     = AW'(p_new_s2) + AW'(p_old_s2);
	assign acc_adj = acc + ((acc < 0) ? AW'((1 << SCALE_W) - 1) : AW'(0));
	assign y_full  = acc_adj >>> SCALE_W;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_prev_q <= '0;
		end else if (v_s2) begin
			filter_prev_q <= y_full[PREV_W-1:0];
		end
	end

	// Stage 4: drop the fraction bits, rounding toward zero.
	assign prev_adj   = filter_prev_q
		+ ((filter_prev_q < 0) ? PREV_W'((1 << FRAC_BITS) - 1) : PREV_W'(0));
	assign whole_full = prev_adj >>> FRAC_BITS;

	always_ff @(posedge clk) begin
		if (v_s3) begin
			whole_s4 <= whole_full[RATE_W-1:0];
		end
	end

	assign done  = v_s4;
	assign whole = whole_s4;

endmodule

### hdl/glmf_cell.sv
// One median cell: holds one history value and ranks it against values passing along the chain.
// Depends on glmf_pkg.
module glmf_cell import glmf_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF,
	parameter int SLOT   = 0,
	localparam int IDX_W = $clog2(WINDOW)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cell_ctrl_t               ctrl,
	input  logic                     wr_en,
	input  logic signed [RATE_W-1:0] wr_data,
	input  logic signed [RATE_W-1:0] circ_val_in,
	input  logic [IDX_W-1:0]         circ_idx_in,
	output logic signed [RATE_W-1:0] circ_val_out,
	output logic [IDX_W-1:0]         circ_idx_out,
	output logic                     is_med,
	output logic signed [RATE_W-1:0] med_val
);

	localparam logic [IDX_W-1:0] MY_SLOT  = IDX_W'(SLOT);
	localparam logic [IDX_W-1:0] MED_RANK = IDX_W'(WINDOW / 2);

	logic signed [RATE_W-1:0] own_q;
	logic signed [RATE_W-1:0] circ_val_q;
	logic [IDX_W-1:0]         circ_idx_q;
	logic [IDX_W-1:0]         rank_q;
	logic                     below;

	// History value, cleared at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q <= '0;
		end else if (wr_en) begin
			own_q <= wr_data;
		end
	end

	// Equal values are ordered by slot so that every rank is distinct.
	assign below = (circ_val_in < own_q) || ((circ_val_in == own_q) && (circ_idx_in < MY_SLOT));

	// Circulating copy and rank count.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			circ_val_q <= own_q;
			circ_idx_q <= MY_SLOT;
			rank_q     <= '0;
		end else if (ctrl.shift) begin
			circ_val_q <= circ_val_in;
			circ_idx_q <= circ_idx_in;
			if (below) begin
				rank_q <= rank_q + 1'b1;
			end
		end
	end

	assign circ_val_out = circ_val_q;
	assign circ_idx_out = circ_idx_q;
	assign is_med       = (rank_q == MED_RANK);
	assign med_val      = is_med ? own_q : '0;

endmodule

### sim/tb_gyro_lowpass_median_filter_unit.sv
// Self-checking testbench for the gyro low-pass and running median filter unit.
// Predicts every median from its own filter and history model, randomizes both stream sides.
// Depends on glmf_pkg and gyro_lowpass_median_filter_unit.
`timescale 1ns / 1ps

module tb_gyro_lowpass_median_filter_unit;
	import glmf_pkg::*;

	localparam int     HIST_LEN     = WINDOW_DEF;
	localparam longint FRAC_SCALE   = longint'(1) << FRAC_BITS_DEF;
	localparam int     DRAIN_CYCLES = WINDOW_DEF + 15;
	// Register indexes the block does not implement; writes to them must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN_LOW  = REG_ALPHA_Q8 + 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN_HIGH = '1;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [SAMPLE_W-1:0]   s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Predictor state and its copy of the registers.
	longint lp_state;
	int     rate_hist [HIST_LEN];
	int     hist_slot;
	int     bias;
	int     weight;

	// Medians still owed by the block, oldest first.
	logic [RATE_W-1:0] median_due [$];
	int mismatches = 0;

	// Idle controls shared with the stream processes.
	bit tx_idle_en = 1'b1;
	bit rx_idle_en = 1'b1;
	int rx_hold_req = 0;

	gyro_lowpass_median_filter_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 50 MHz clock.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Runs one sample through the low-pass and the history, and returns the upper median.
	function automatic logic [RATE_W-1:0] predict_median_rate(logic [SAMPLE_W-1:0] raw);
		longint x;
		longint a;
		longint acc;
		longint y;
		int     sorted [HIST_LEN];
		int     key;
		int     j;
		x = longint'($signed(raw)) - longint'(bias);
		a = (weight > int'(ALPHA_ONE)) ? longint'(ALPHA_ONE) : longint'(weight);
		acc = a * (x * FRAC_SCALE) + (longint'(ALPHA_ONE) - a) * lp_state;
		// SystemVerilog division truncates toward zero, as the block does.
		y = acc / longint'(ALPHA_ONE);
		lp_state = y;
		rate_hist[hist_slot] = int'(y / FRAC_SCALE);
		hist_slot = (hist_slot + 1) % HIST_LEN;
		sorted = rate_hist;
		for (int p = 1; p < HIST_LEN; p++) begin
			key = sorted[p];
			j = p - 1;
			while (j >= 0 && sorted[j] > key) begin
				sorted[j + 1] = sorted[j];
				j--;
			end
			sorted[j + 1] = key;
		end
		return RATE_W'(sorted[HIST_LEN / 2]);
	endfunction

	task automatic reset_predictor();
		lp_state = 0;
		hist_slot = 0;
		bias = 0;
		weight = int'(ALPHA_RESET);
		foreach (rate_hist[p])
			rate_hist[p] = 0;
	endtask

	// Offers one sample, after a random gap while input idles are enabled, and records the median it must produce.
	task automatic send_sample(logic [SAMPLE_W-1:0] raw);
		int gap;
		gap = tx_idle_en ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= raw;
		do @(posedge clk); while (!s_tready);
		median_due.push_back(predict_median_rate(raw));
	endtask

	task automatic release_input();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// Waits until every owed median has arrived, then lets the pipeline settle.
	task automatic wait_for_idle();
		int guard;
		guard = 0;
		while (median_due.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One register write transfer; the predictor follows only the implemented registers.
	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_ZERO_OFFSET)
			bias = int'($signed(val));
		else if (idx == REG_ALPHA_Q8)
			weight = int'(val[ALPHA_W-1:0]);
		@(posedge clk);
	endtask

	// Reset registers: zeros of the history take part in the first medians.
	task automatic test_startup_defaults();
		send_sample(16'sd0);
		send_sample(16'sd32767);
		send_sample(16'sd32767);
		send_sample(-16'sd32768);
		send_sample(16'sd1);
		send_sample(-16'sd1);
		send_sample(16'h5555);
		send_sample(16'hAAAA);
		release_input();
		wait_for_idle();
	endtask

	// Register extremes, weight above one, zero weight and writes to unknown indexes.
	task automatic test_register_extremes();
		// Largest positive difference with a pass-through filter.
		write_register(REG_ZERO_OFFSET, 16'h8000);
		write_register(REG_ALPHA_Q8, CFG_DATA_W'(ALPHA_ONE));
		send_sample(16'sd32767);
		send_sample(-16'sd32768);
		release_input();
		wait_for_idle();
		// Largest negative difference; the weight saturates to one.
		write_register(REG_ZERO_OFFSET, 16'h7FFF);
		write_register(REG_ALPHA_Q8, 16'hFFFF);
		send_sample(-16'sd32768);
		send_sample(16'sd0);
		release_input();
		wait_for_idle();
		// Zero weight holds the filter where it is.
		write_register(REG_ALPHA_Q8, 16'h0000);
		send_sample(16'sd32767);
		send_sample(-16'sd32768);
		release_input();
		wait_for_idle();
		// Unknown indexes must leave both registers alone.
		write_register(REG_UNKNOWN_LOW, 16'hFFFF);
		write_register(REG_UNKNOWN_HIGH, 16'h0101);
		write_register(REG_ALPHA_Q8, 16'hFE80);
		send_sample(16'sd12345);
		send_sample(-16'sd23456);
		release_input();
		wait_for_idle();
	endtask

	// Phases of random samples, each under its own register setting and idle pattern.
	task automatic test_random_phases();
		logic [SAMPLE_W-1:0] raw;
		logic [CFG_DATA_W-1:0] val;
		for (int phase = 0; phase < 8; phase++) begin
			case ($urandom_range(0, 3))
				0: val = 16'h8000;
				1: val = 16'h7FFF;
				2: val = CFG_DATA_W'($urandom);
				default: val = CFG_DATA_W'($urandom_range(0, 400)) - 16'd200;
			endcase
			write_register(REG_ZERO_OFFSET, val);
			case ($urandom_range(0, 3))
				0: val = 16'h0000;
				1: val = CFG_DATA_W'(ALPHA_ONE);
				2: val = CFG_DATA_W'($urandom);
				default: val = CFG_DATA_W'($urandom_range(1, 255));
			endcase
			write_register(REG_ALPHA_Q8, val);
			write_register(CFG_IDX_W'($urandom_range(int'(REG_UNKNOWN_LOW), 255)),
				CFG_DATA_W'($urandom));
			tx_idle_en = (phase % 3) != 2;
			rx_idle_en = (phase % 4) != 1;
			for (int n = 0; n < 200; n++) begin
				case ($urandom_range(0, 9))
					0: raw = ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
					1, 2: raw = SAMPLE_W'(bias) + SAMPLE_W'($urandom_range(0, 64)) - 16'd32;
					default: raw = SAMPLE_W'($urandom);
				endcase
				send_sample(raw);
			end
			release_input();
			wait_for_idle();
		end
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	// The receiver holds off for a long stretch while samples keep coming.
	task automatic test_output_backpressure();
		tx_idle_en = 1'b0;
		rx_hold_req = 300;
		for (int n = 0; n < 24; n++)
			send_sample(SAMPLE_W'($urandom));
		release_input();
		tx_idle_en = 1'b1;
		wait_for_idle();
	endtask

	// Result receiver: random stalls per transfer, plus an occasional long hold-off.
	initial begin : result_sink
		int stall;
		m_tready = 1'b0;
		@(posedge clk);
		forever begin
			if (rx_hold_req > 0) begin
				m_tready <= 1'b0;
				repeat (rx_hold_req) @(posedge clk);
				rx_hold_req = 0;
			end
			stall = rx_idle_en ? $urandom_range(0, 4) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid && rx_hold_req == 0);
		end
	end

	// Compares each result transfer with the oldest owed median and checks the zero padding.
	always @(posedge clk) begin
		logic [RATE_W-1:0] due;
		if (arst_n && m_tvalid && m_tready) begin
			if (median_due.size() == 0) begin
				$display("%0t ERROR: unexpected result, expected none, actual %0d",
					$time, $signed(m_tdata[RATE_W-1:0]));
				mismatches++;
			end else begin
				due = median_due.pop_front();
				if (m_tdata[RATE_W-1:0] !== due) begin
					$display("%0t ERROR: median_rate expected %0d actual %0d",
						$time, $signed(due), $signed(m_tdata[RATE_W-1:0]));
					mismatches++;
				end
				if (m_tdata[M_TDATA_W-1:RATE_W] !== '0) begin
					$display("%0t ERROR: tdata padding expected 0x0 actual 0x%0h",
						$time, m_tdata[M_TDATA_W-1:RATE_W]);
					mismatches++;
				end
			end
		end
	end

	// Main sequence.
	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		reset_predictor();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_startup_defaults();
		test_register_extremes();
		test_random_phases();
		test_output_backpressure();

		wait_for_idle();
		while (median_due.size() != 0) begin
			$display("%0t ERROR: median_rate expected %0d actual none",
				$time, $signed(median_due.pop_front()));
			mismatches++;
		end
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#10_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
